FILE: src/escaped_block_receive_deframer_macros.svh
// Assertion macros for the assertion checker of the deframer.
`ifndef ESCAPED_BLOCK_RECEIVE_DEFRAMER_MACROS_SVH
`define ESCAPED_BLOCK_RECEIVE_DEFRAMER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define EBRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition leads to a consequence on the next clock edge.
`define EBRD_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (conseq)) else $error(msg);

`endif

FILE: src/ebrd_pkg.sv
package ebrd_pkg;

   // Field widths of the transfer payloads.
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 11;
   localparam int LIMIT_W  = 11;

   // Configuration port geometry.
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int REG_IDX_W = 3;

   // Command codes carried by the request channel.
   localparam logic [CMD_W-1:0] CMD_BYTE      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARM       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHAR_MODE = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_START_CODE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_END_CODE     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ESCAPE_MASK  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RESTART_CODE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BLOCK_LIMIT  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DELIVER_EN   = 3'd6;

   // Register reset values.
   localparam logic [BYTE_W-1:0]  RST_ESCAPE_MASK = 8'd128;
   localparam logic [LIMIT_W-1:0] RST_BLOCK_LIMIT = 11'd1024;

   // Decoded kind of a request.
   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_ARM,
      KIND_CHAR_MODE,
      KIND_NONE
   } kind_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [BYTE_W-1:0]  start_code;
      logic [BYTE_W-1:0]  end_code;
      logic [BYTE_W-1:0]  escape_code;
      logic [BYTE_W-1:0]  escape_flag_mask;
      logic [BYTE_W-1:0]  restart_code;
      logic [LIMIT_W-1:0] block_limit;
      logic               deliver_enable;
   } cfg_type;

   // A classified request, as it travels from the front end to the back end.
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] mapped_byte;
      logic              rx_error;
      logic              tx_active;
      logic              is_start;
      logic              is_end;
      logic              is_escape;
      logic              is_restart;
      logic              has_flag;
   } cls_type;

endpackage

FILE: src/ebrd_req_if.sv
interface ebrd_req_if;
   import ebrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] rx_byte;
   logic              rx_error;
   logic              tx_active;

   modport source (output valid, command, rx_byte, rx_error, tx_active, input ready);
   modport sink   (input valid, command, rx_byte, rx_error, tx_active, output ready);
endinterface

FILE: src/ebrd_rsp_if.sv
interface ebrd_rsp_if;
   import ebrd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                deliver_valid;
   logic                store_valid;
   logic [OFFSET_W-1:0] store_offset;
   logic                block_done;
   logic                send_restart;
   logic                tx_restart;
   logic [COUNT_W-1:0]  byte_count;

   modport source (output valid, out_byte, deliver_valid, store_valid, store_offset,
                   block_done, send_restart, tx_restart, byte_count, input ready);
   modport sink   (input valid, out_byte, deliver_valid, store_valid, store_offset,
                   block_done, send_restart, tx_restart, byte_count, output ready);
endinterface

FILE: src/ebrd_front.sv
module ebrd_front (
   ebrd_req_if.sink          req_chan,
   input  ebrd_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output ebrd_pkg::cls_type cls
);
   import ebrd_pkg::*;

   // A transfer is taken whenever the queue has room.
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Decode the command and compare the byte against the control codes.
   always_comb begin
      case (req_chan.command)
         CMD_BYTE:      cls.kind = KIND_BYTE;
         CMD_ARM:       cls.kind = KIND_ARM;
         CMD_CHAR_MODE: cls.kind = KIND_CHAR_MODE;
         default:       cls.kind = KIND_NONE;
      endcase
      cls.rx_byte     = req_chan.rx_byte;
      cls.mapped_byte = req_chan.rx_byte | cfg.escape_flag_mask;
      cls.rx_error    = req_chan.rx_error;
      cls.tx_active   = req_chan.tx_active;
      cls.is_start    = (req_chan.rx_byte == cfg.start_code);
      cls.is_end      = (req_chan.rx_byte == cfg.end_code);
      cls.is_escape   = (req_chan.rx_byte == cfg.escape_code);
      cls.is_restart  = (req_chan.rx_byte == cfg.restart_code);
      cls.has_flag    = ((req_chan.rx_byte & cfg.escape_flag_mask) != '0);
   end
endmodule

FILE: src/ebrd_queue.sv
module ebrd_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ebrd_pkg::cls_type push_data,
   input  logic              pop,
   output ebrd_pkg::cls_type pop_data,
   output logic              full,
   output logic              empty
);
   import ebrd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   cls_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: src/ebrd_back.sv
module ebrd_back #(
   parameter int BLOCK_MAX = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  ebrd_pkg::cfg_type cfg,
   input  ebrd_pkg::cls_type cls,
   input  logic              queue_empty,
   output logic              pop,
   ebrd_rsp_if.source        rsp_chan
);
   import ebrd_pkg::*;

   localparam int MAX_W = $clog2(BLOCK_MAX + 1);
   localparam int CMP_W = (MAX_W > COUNT_W + 1) ? MAX_W : COUNT_W + 1;

   typedef enum logic [2:0] {
      PH_CHAR,
      PH_READY,
      PH_READ,
      PH_WAIT,
      PH_DONE
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                escape_ff, escape_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                deliver_ff, deliver_in;
   logic                store_ff, store_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                done_ff, done_in;
   logic                send_restart_ff, send_restart_in;
   logic                tx_restart_ff, tx_restart_in;

   logic [CMP_W-1:0]    limit_eff;
   logic [CMP_W-1:0]    count_plus;
   logic                limit_hit;
   logic                out_free;

   // The result register takes a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = out_free && !queue_empty;

   // Effective block limit is capped at the buffer size.
   assign limit_eff  = (CMP_W'(cfg.block_limit) > CMP_W'(BLOCK_MAX)) ?
                       CMP_W'(BLOCK_MAX) : CMP_W'(cfg.block_limit);
   assign count_plus = CMP_W'(count_ff) + 1'b1;
   assign limit_hit  = (count_plus >= limit_eff);

   // Phase machine: work out the next state and the result of one item.
   always_comb begin
      phase_in        = phase_ff;
      escape_in       = escape_ff;
      count_in        = count_ff;
      out_byte_in     = '0;
      deliver_in      = 1'b0;
      store_in        = 1'b0;
      offset_in       = '0;
      done_in         = 1'b0;
      send_restart_in = 1'b0;
      tx_restart_in   = 1'b0;
      case (cls.kind)
         KIND_ARM: begin
            phase_in  = PH_READY;
            escape_in = 1'b0;
            count_in  = '0;
         end
         KIND_CHAR_MODE: begin
            phase_in  = PH_CHAR;
            escape_in = 1'b0;
            count_in  = '0;
         end
         KIND_BYTE: begin
            case (phase_ff)
               PH_CHAR: begin
                  if (cls.is_restart && cls.tx_active) begin
                     tx_restart_in = 1'b1;
                  end else if (cfg.deliver_enable) begin
                     out_byte_in = cls.rx_byte;
                     deliver_in  = 1'b1;
                  end
               end
               PH_READY: begin
                  if (cls.is_start) begin
                     phase_in = PH_READ;
                  end else begin
                     send_restart_in = 1'b1;
                     phase_in        = PH_WAIT;
                  end
               end
               PH_READ: begin
                  if (cls.rx_error || (escape_ff && !cls.is_end && !cls.is_start &&
                                       cls.has_flag)) begin
                     // Line error or impossible escape: drop the block.
                     phase_in        = PH_WAIT;
                     escape_in       = 1'b0;
                     count_in        = '0;
                     send_restart_in = 1'b1;
                  end else if (cls.is_end) begin
                     phase_in = PH_DONE;
                     done_in  = 1'b1;
                  end else if (cls.is_start) begin
                     escape_in = 1'b0;
                     count_in  = '0;
                  end else if (!escape_ff && cls.is_escape) begin
                     escape_in = 1'b1;
                  end else begin
                     // Store a plain byte, or an escaped byte with its flag set.
                     escape_in   = 1'b0;
                     out_byte_in = escape_ff ? cls.mapped_byte : cls.rx_byte;
                     store_in    = 1'b1;
                     offset_in   = count_ff[OFFSET_W-1:0];
                     count_in    = count_plus[COUNT_W-1:0];
                     if (limit_hit) begin
                        phase_in = PH_DONE;
                        done_in  = 1'b1;
                     end
                  end
               end
               PH_WAIT: begin
                  if (cls.is_start) begin
                     phase_in = PH_READ;
                  end else if (cls.is_end) begin
                     phase_in = PH_READY;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CHAR;
         escape_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            escape_ff <= escape_in;
            count_ff  <= count_in;
         end
         if (out_free) begin
            rsp_valid_ff <= !queue_empty;
         end
      end
      if (pop) begin
         out_byte_ff     <= out_byte_in;
         deliver_ff      <= deliver_in;
         store_ff        <= store_in;
         offset_ff       <= offset_in;
         done_ff         <= done_in;
         send_restart_ff <= send_restart_in;
         tx_restart_ff   <= tx_restart_in;
      end
   end

   // The byte count of a result is the count held after that item.
   logic [COUNT_W-1:0] byte_count_ff;
   always_ff @(posedge clock) begin
      if (pop) begin
         byte_count_ff <= count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = out_byte_ff;
   assign rsp_chan.deliver_valid = deliver_ff;
   assign rsp_chan.store_valid   = store_ff;
   assign rsp_chan.store_offset  = offset_ff;
   assign rsp_chan.block_done    = done_ff;
   assign rsp_chan.send_restart  = send_restart_ff;
   assign rsp_chan.tx_restart    = tx_restart_ff;
   assign rsp_chan.byte_count    = byte_count_ff;
endmodule

FILE: src/escaped_block_receive_deframer.sv
// Requests are queued, then processed into registered results. Throughput:
// one request per cycle while the queue has room; the back end's phase
// machine takes one queued item per cycle while the result register drains.
// Reset: synchronous, active high; clears phase, escape flag, stored count,
// the queue pointers and the result valid flag, and loads the register defaults.
module escaped_block_receive_deframer #(
   parameter int BLOCK_MAX   = 1024,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   ebrd_req_if.sink                        req_chan,
   ebrd_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ebrd_pkg::ADDR_W-1:0]     paddr,
   input  logic [ebrd_pkg::DATA_W-1:0]     pwdata,
   output logic [ebrd_pkg::DATA_W-1:0]     prdata,
   output logic                            pready
);
   import ebrd_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  cfg_write;
   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_empty;
   cls_type               push_cls;
   cls_type               pop_cls;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_idx)
            REG_START_CODE:   cfg_in.start_code       = pwdata[BYTE_W-1:0];
            REG_END_CODE:     cfg_in.end_code         = pwdata[BYTE_W-1:0];
            REG_ESCAPE_CODE:  cfg_in.escape_code      = pwdata[BYTE_W-1:0];
            REG_ESCAPE_MASK:  cfg_in.escape_flag_mask = pwdata[BYTE_W-1:0];
            REG_RESTART_CODE: cfg_in.restart_code     = pwdata[BYTE_W-1:0];
            REG_BLOCK_LIMIT:  cfg_in.block_limit      = pwdata[LIMIT_W-1:0];
            REG_DELIVER_EN:   cfg_in.deliver_enable   = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code       <= '0;
         cfg_ff.end_code         <= '0;
         cfg_ff.escape_code      <= '0;
         cfg_ff.escape_flag_mask <= RST_ESCAPE_MASK;
         cfg_ff.restart_code     <= '0;
         cfg_ff.block_limit      <= RST_BLOCK_LIMIT;
         cfg_ff.deliver_enable   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux.
   always_comb begin
      case (reg_idx)
         REG_START_CODE:   prdata = DATA_W'(cfg_ff.start_code);
         REG_END_CODE:     prdata = DATA_W'(cfg_ff.end_code);
         REG_ESCAPE_CODE:  prdata = DATA_W'(cfg_ff.escape_code);
         REG_ESCAPE_MASK:  prdata = DATA_W'(cfg_ff.escape_flag_mask);
         REG_RESTART_CODE: prdata = DATA_W'(cfg_ff.restart_code);
         REG_BLOCK_LIMIT:  prdata = DATA_W'(cfg_ff.block_limit);
         REG_DELIVER_EN:   prdata = DATA_W'(cfg_ff.deliver_enable);
         default:          prdata = '0;
      endcase
   end

   // Front end: accept and classify requests.
   ebrd_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .cls        (push_cls)
   );

   // Queue between the front and back ends.
   ebrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cls),
      .pop       (pop),
      .pop_data  (pop_cls),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Back end: phase machine and result register.
   ebrd_back #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cls         (pop_cls),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );
endmodule

FILE: src/ebrd_checker.sv
`include "escaped_block_receive_deframer_macros.svh"

module ebrd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ebrd_pkg::BYTE_W-1:0]   out_byte,
   input logic                          deliver_valid,
   input logic                          store_valid,
   input logic [ebrd_pkg::OFFSET_W-1:0] store_offset,
   input logic                          block_done,
   input logic                          send_restart
);
   import ebrd_pkg::*;

   // A stalled result stays offered.
   `EBRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // A stalled result keeps its byte and offset.
   `EBRD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(out_byte) && $stable(store_offset), "result changed while stalled")

   // A byte goes either to the consumer or to the buffer, never both.
   `EBRD_ASSERT(a_one_sink, rsp_valid |-> !(deliver_valid && store_valid), "byte sent to both sinks")

   // Without a store, offset is zero; without any byte, the byte is zero; done and restart are never both set.
   `EBRD_ASSERT(a_idle_zero, rsp_valid && !store_valid |-> store_offset == '0 && (deliver_valid || out_byte == '0) && !(block_done && send_restart), "idle result fields not cleared")
endmodule

bind escaped_block_receive_deframer ebrd_checker u_ebrd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .out_byte      (rsp_chan.out_byte),
   .deliver_valid (rsp_chan.deliver_valid),
   .store_valid   (rsp_chan.store_valid),
   .store_offset  (rsp_chan.store_offset),
   .block_done    (rsp_chan.block_done),
   .send_restart  (rsp_chan.send_restart)
);

FILE: test/deframe_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the deframer, keeps its own
// copy of the phase machine, and compares every result transfer with the
// oldest prediction.
module deframe_checker #(
   parameter int BLOCK_MAX = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   ebrd_req_if                         req_mon,
   ebrd_rsp_if                         rsp_mon,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ebrd_pkg::ADDR_W-1:0] paddr,
   input  logic [ebrd_pkg::DATA_W-1:0] pwdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          waiting_count
);
   import ebrd_pkg::*;

   typedef enum logic [2:0] {
      MODE_CHAR,
      MODE_READY,
      MODE_READING,
      MODE_WAITING,
      MODE_DONE
   } rx_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                deliver_valid;
      logic                store_valid;
      logic [OFFSET_W-1:0] store_offset;
      logic                block_done;
      logic                send_restart;
      logic                tx_restart;
      logic [COUNT_W-1:0]  byte_count;
   } deframe_result_type;

   // Register copies, loaded from observed register writes.
   logic [BYTE_W-1:0]  start_code;
   logic [BYTE_W-1:0]  end_code;
   logic [BYTE_W-1:0]  escape_code;
   logic [BYTE_W-1:0]  flag_mask;
   logic [BYTE_W-1:0]  restart_code;
   logic [LIMIT_W-1:0] block_limit;
   logic               deliver_en;

   // Receive state of the predicted block.
   rx_mode_type mode;
   logic        esc_pending;
   int unsigned stored;

   deframe_result_type pending_results[$];
   deframe_result_type want;
   int fails = 0;
   int waiting = 0;

   assign fail_count    = fails;
   assign waiting_count = waiting;

   task automatic report_mismatch(input string what);
      fails++;
      $display("[%0t] deframer mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [10:0] got,
                              input logic [10:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
   endtask

   // Advances the predicted state by one request and returns its result.
   function automatic deframe_result_type predict_transfer(input logic [CMD_W-1:0] cmd,
                                                           input logic [BYTE_W-1:0] ch,
                                                           input logic err,
                                                           input logic txa);
      deframe_result_type r;
      logic [BYTE_W-1:0] data;
      logic drop;
      int unsigned cap;
      r = '0;
      data = ch;
      drop = 1'b0;
      cap = (int'(block_limit) > BLOCK_MAX) ? BLOCK_MAX : int'(block_limit);
      case (cmd)
         CMD_ARM: begin
            mode = MODE_READY;
            stored = 0;
            esc_pending = 1'b0;
         end
         CMD_CHAR_MODE: begin
            mode = MODE_CHAR;
            stored = 0;
            esc_pending = 1'b0;
         end
         CMD_BYTE: begin
            case (mode)
               MODE_CHAR: begin
                  if (ch == restart_code && txa) begin
                     r.tx_restart = 1'b1;
                  end else if (deliver_en) begin
                     r.out_byte = ch;
                     r.deliver_valid = 1'b1;
                  end
               end
               MODE_READY: begin
                  if (ch == start_code) begin
                     mode = MODE_READING;
                  end else begin
                     r.send_restart = 1'b1;
                     mode = MODE_WAITING;
                  end
               end
               MODE_READING: begin
                  // Line error first, then end, then start, then escape handling.
                  if (err) begin
                     drop = 1'b1;
                  end else if (ch == end_code) begin
                     mode = MODE_DONE;
                     r.block_done = 1'b1;
                  end else if (ch == start_code) begin
                     esc_pending = 1'b0;
                     stored = 0;
                  end else if (esc_pending && (ch & flag_mask) != '0) begin
                     drop = 1'b1;
                  end else if (!esc_pending && ch == escape_code) begin
                     esc_pending = 1'b1;
                  end else begin
                     if (esc_pending)
                        data = ch | flag_mask;
                     esc_pending = 1'b0;
                     r.out_byte = data;
                     r.store_valid = 1'b1;
                     r.store_offset = stored[OFFSET_W-1:0];
                     stored++;
                     // A zero limit completes on the first stored byte.
                     if (stored >= cap) begin
                        mode = MODE_DONE;
                        r.block_done = 1'b1;
                     end
                  end
                  if (drop) begin
                     mode = MODE_WAITING;
                     stored = 0;
                     esc_pending = 1'b0;
                     r.send_restart = 1'b1;
                  end
               end
               MODE_WAITING: begin
                  if (ch == start_code)
                     mode = MODE_READING;
                  else if (ch == end_code)
                     mode = MODE_READY;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.byte_count = stored[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start_code   = '0;
         end_code     = '0;
         escape_code  = '0;
         flag_mask    = RST_ESCAPE_MASK;
         restart_code = '0;
         block_limit  = RST_BLOCK_LIMIT;
         deliver_en   = 1'b0;
         mode         = MODE_CHAR;
         esc_pending  = 1'b0;
         stored       = 0;
         pending_results.delete();
      end else begin
         // Register writes take effect at the access edge.
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_START_CODE:   start_code   = pwdata[BYTE_W-1:0];
               REG_END_CODE:     end_code     = pwdata[BYTE_W-1:0];
               REG_ESCAPE_CODE:  escape_code  = pwdata[BYTE_W-1:0];
               REG_ESCAPE_MASK:  flag_mask    = pwdata[BYTE_W-1:0];
               REG_RESTART_CODE: restart_code = pwdata[BYTE_W-1:0];
               REG_BLOCK_LIMIT:  block_limit  = pwdata[LIMIT_W-1:0];
               REG_DELIVER_EN:   deliver_en   = pwdata[0];
               default: ;
            endcase
         end

         // Each request transfer yields exactly one predicted result.
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(predict_transfer(req_mon.command, req_mon.rx_byte,
                                                       req_mon.rx_error, req_mon.tx_active));

         // Compare a result transfer with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", 11'(rsp_mon.out_byte), 11'(want.out_byte));
               check_field("deliver_valid", 11'(rsp_mon.deliver_valid),
                           11'(want.deliver_valid));
               check_field("store_valid", 11'(rsp_mon.store_valid), 11'(want.store_valid));
               check_field("store_offset", 11'(rsp_mon.store_offset),
                           11'(want.store_offset));
               check_field("block_done", 11'(rsp_mon.block_done), 11'(want.block_done));
               check_field("send_restart", 11'(rsp_mon.send_restart),
                           11'(want.send_restart));
               check_field("tx_restart", 11'(rsp_mon.tx_restart), 11'(want.tx_restart));
               check_field("byte_count", rsp_mon.byte_count, want.byte_count);
            end
         end
      end
      waiting = pending_results.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ebrd_pkg::*;

   localparam int BLOCK_MAX = 1024;
   localparam int HALF_PERIOD = 4;
   localparam int RUN_LIMIT_CYCLES = 400000;
   // The command value the block decodes as no operation.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   int fail_count;
   int waiting_count;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int settings_used = 0;

   // Current register values, used to shape well-formed blocks.
   logic [BYTE_W-1:0]  start_code;
   logic [BYTE_W-1:0]  end_code;
   logic [BYTE_W-1:0]  escape_code;
   logic [BYTE_W-1:0]  flag_mask;
   logic [BYTE_W-1:0]  restart_code;
   logic [LIMIT_W-1:0] block_limit;
   logic               deliver_en;

   ebrd_req_if req_bus();
   ebrd_rsp_if rsp_bus();

   escaped_block_receive_deframer #(
      .BLOCK_MAX(BLOCK_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   deframe_checker #(
      .BLOCK_MAX(BLOCK_MAX)
   ) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // Random values sized to the fields they feed.
   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Result side backpressure.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs.
   initial begin
      #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      logic taken;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         taken = pready;
         @(posedge clock);
      end while (!taken);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Holds the request side idle until every outstanding result has arrived.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (waiting_count != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_setting(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                               input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] m,
                               input logic [BYTE_W-1:0] r, input logic [LIMIT_W-1:0] lim,
                               input logic den);
      drain();
      start_code   = s;
      end_code     = e;
      escape_code  = x;
      flag_mask    = m;
      restart_code = r;
      block_limit  = lim;
      deliver_en   = den;
      settings_used++;
      write_reg(REG_START_CODE, {24'd0, s});
      write_reg(REG_END_CODE, {24'd0, e});
      write_reg(REG_ESCAPE_CODE, {24'd0, x});
      write_reg(REG_ESCAPE_MASK, {24'd0, m});
      write_reg(REG_RESTART_CODE, {24'd0, r});
      write_reg(REG_BLOCK_LIMIT, {21'd0, lim});
      write_reg(REG_DELIVER_EN, {31'd0, den});
   endtask

   // Random framing codes, with distinct start, end and escape codes.
   task automatic load_random_setting(input logic [BYTE_W-1:0] m,
                                      input logic [LIMIT_W-1:0] lim, input logic den);
      logic [BYTE_W-1:0] s;
      logic [BYTE_W-1:0] e;
      logic [BYTE_W-1:0] x;
      s = rand_byte();
      do e = rand_byte(); while (e == s);
      do x = rand_byte(); while (x == s || x == e);
      load_setting(s, e, x, m, rand_byte(), lim, den);
   endtask

   // One request transfer, preceded by random idle cycles.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] ch,
                            input logic err, input logic txa);
      logic taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.rx_byte   <= ch;
      req_bus.rx_error  <= err;
      req_bus.tx_active <= txa;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] ch);
      send_item(CMD_BYTE, ch, 1'b0, rand_bit());
   endtask

   // A byte that carries no framing meaning under the current setting.
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = rand_byte();
      while (b == start_code || b == end_code || b == escape_code);
      return b;
   endfunction

   // Arm, open, fill with mostly clean data, and usually close a block.
   task automatic send_block();
      int cap;
      int len;
      int roll;
      cap = (block_limit == 0) ? 1 :
            ((int'(block_limit) > BLOCK_MAX) ? BLOCK_MAX : int'(block_limit));
      len = int'($urandom_range(0, (cap + 1 < 20) ? cap + 1 : 20));
      send_item(CMD_ARM, rand_byte(), rand_bit(), rand_bit());
      if ($urandom_range(0, 9) == 0)
         send_byte(plain_byte());
      send_byte(start_code);
      for (int k = 0; k < len; k++) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 12) begin
            send_byte(escape_code);
            if ($urandom_range(0, 3) == 0)
               send_byte(rand_byte());
            else
               send_byte(rand_byte() & ~flag_mask);
         end else if (roll < 15) begin
            send_item(CMD_BYTE, rand_byte(), 1'b1, rand_bit());
         end else if (roll < 17) begin
            send_byte(start_code);
         end else begin
            send_byte(plain_byte());
         end
      end
      if ($urandom_range(0, 9) != 0)
         send_byte(end_code);
   endtask

   // Mix of blocks, character-mode traffic and raw noise, with one full pause.
   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      int stop_at;
      int hold_at;
      int roll;
      logic held;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = items_sent + count;
      hold_at = items_sent + count / 2;
      held = 1'b0;
      while (items_sent < stop_at) begin
         if (!held && items_sent >= hold_at) begin
            drain();
            held = 1'b1;
         end
         roll = int'($urandom_range(0, 99));
         if (roll < 65) begin
            send_block();
         end else if (roll < 80) begin
            send_item(CMD_CHAR_MODE, rand_byte(), rand_bit(), rand_bit());
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 9) < 3)
                  send_item(CMD_BYTE, restart_code, rand_bit(), rand_bit());
               else
                  send_item(CMD_BYTE, rand_byte(), rand_bit(), rand_bit());
            end
         end else begin
            send_item(CMD_W'($urandom_range(0, 3)), rand_byte(), rand_bit(), rand_bit());
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= CMD_BYTE;
      req_bus.rx_byte   <= '0;
      req_bus.rx_error  <= 1'b0;
      req_bus.tx_active <= 1'b0;
      start_code   = '0;
      end_code     = '0;
      escape_code  = '0;
      flag_mask    = RST_ESCAPE_MASK;
      restart_code = '0;
      block_limit  = RST_BLOCK_LIMIT;
      deliver_en   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: every framing code is zero.
      run_random(40, 0, 0);

      // Directed cases, with a limit above the buffer size.
      load_setting(8'h02, 8'h03, 8'h10, 8'h80, 8'h18, 11'd2047, 1'b1);
      send_item(CMD_BYTE, 8'h41, 1'b0, 1'b1);
      send_item(CMD_BYTE, restart_code, 1'b0, 1'b1);
      send_item(CMD_BYTE, restart_code, 1'b0, 1'b0);
      // A line error in character mode is ignored.
      send_item(CMD_BYTE, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_ARM, 8'h00, 1'b0, 1'b0);
      // Ready phase: a non-start byte asks for restart, end returns to ready.
      send_item(CMD_BYTE, 8'h55, 1'b0, 1'b0);
      send_item(CMD_BYTE, end_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h00, 1'b1, 1'b0);
      send_item(CMD_BYTE, start_code, 1'b0, 1'b1);
      send_item(CMD_BYTE, 8'hFF, 1'b0, 1'b1);
      // A start byte while reading restarts the block.
      send_item(CMD_BYTE, start_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
      send_item(CMD_BYTE, escape_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h7F, 1'b0, 1'b0);
      // An escaped byte that already carries the flag discards the block.
      send_item(CMD_BYTE, escape_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h80, 1'b0, 1'b0);
      send_item(CMD_BYTE, start_code, 1'b0, 1'b0);
      // The end byte wins over a pending escape, then bytes are ignored.
      send_item(CMD_BYTE, escape_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, end_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h41, 1'b0, 1'b1);
      send_item(CMD_ARM, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_BYTE, start_code, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'h41, 1'b1, 1'b0);
      send_item(CMD_CHAR_MODE, 8'hFF, 1'b1, 1'b1);

      // A longer block that runs on under the oversized limit until its end byte.
      send_item(CMD_ARM, 8'h00, 1'b0, 1'b0);
      send_byte(start_code);
      repeat (24) send_byte(plain_byte());
      send_byte(end_code);

      load_random_setting(rand_byte(), LIMIT_W'($urandom_range(2, 12)), 1'b1);
      run_random(110, 70, 0);
      load_random_setting(8'hFF, 11'd0, 1'b0);
      run_random(100, 0, 70);
      load_random_setting(8'h01, 11'd1, 1'b1);
      run_random(100, 26, 26);
      load_setting(8'hFF, 8'h00, 8'h7D, 8'h00, 8'hFF, 11'd1024, 1'b0);
      run_random(100, 0, 0);
      load_random_setting(rand_byte(), LIMIT_W'($urandom_range(3, 16)), rand_bit());
      run_random(100, 70, 0);

      drain();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests under %0d register settings, with an oversized limit,",
               items_sent, settings_used);
      $display("framing errors, escapes, noise commands and every idle and stall pattern.");
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
